// File: src/pfor_pkg.sv
// ----------------------------------------------------------------------------
// pfor_pkg
// Shared constants, codes and types of the patched frame-of-reference decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pfor_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W      = 2;
    localparam int GAP_IN_W   = 4;
    localparam int VALUE_W    = 64;
    localparam int WORD_BITS  = 32;
    localparam int VSLOT_W    = 6;
    localparam int CONSUMED_W = 16;
    localparam int LEFT_OUT_W = 4;

    // Code geometry and exception queue size
    localparam int SLOT_BITS      = 4;
    localparam int EXC_DEPTH      = 16;
    localparam int SLOTS_PER_WORD = WORD_BITS / SLOT_BITS;
    localparam int EXC_AW         = $clog2(EXC_DEPTH);
    localparam int LVL_W          = $clog2(EXC_DEPTH + 1);
    localparam int LEFT_W         = $clog2(SLOTS_PER_WORD + 1);

    localparam logic [CONSUMED_W-1:0] CONSUMED_MAX = '1;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_DECODE = 2'd2
    } t_cmd;

    // Slot sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // One decoded result item
    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic                  last;
        logic                  was_exception;
        logic                  queue_empty_error;
        logic                  push_overflow;
        logic [CONSUMED_W-1:0] exceptions_consumed;
        logic [LEFT_OUT_W-1:0] countdown_left;
    } t_result;

    // Exception queue status toward the sequencer
    typedef struct packed {
        logic empty;
        logic overflow;
    } t_fifo_stat;

endpackage

`default_nettype wire

// File: src/pfor_ram.sv
// ----------------------------------------------------------------------------
// pfor_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfor_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port and registered read (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/pfor_exc_fifo.sv
// ----------------------------------------------------------------------------
// pfor_exc_fifo
// Exception value queue: RAM storage, head prefetch with write forwarding,
// level tracking and the sticky overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pfor_exc_fifo
    import pfor_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [VALUE_W-1:0] i_push_data,
    input  wire logic               i_pop,
    output logic      [VALUE_W-1:0] o_head_data,
    output t_fifo_stat              o_stat
);

    logic [EXC_AW-1:0]  r_head, r_tail, n_head, n_tail;
    logic [LVL_W-1:0]   r_level, n_level;
    logic               r_overflow;
    logic               r_fwd_hit;
    logic [VALUE_W-1:0] r_fwd_data;
    logic [VALUE_W-1:0] ram_rdata;
    logic               push_ok, pop_ok, full, empty;

    assign full    = (r_level == LVL_W'(EXC_DEPTH));
    assign empty   = (r_level == '0);
    assign push_ok = i_push && !full;
    assign pop_ok  = i_pop && !empty;

    // Pointer and level update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_level = r_level;
        if (pop_ok) begin
            n_head = (r_head == EXC_AW'(EXC_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (push_ok) begin
            n_tail = (r_tail == EXC_AW'(EXC_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_level = r_level + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_level    <= '0;
            r_overflow <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_level   <= n_level;
            if (i_push && full) begin
                r_overflow <= 1'b1;
            end
            // a write landing on the entry being prefetched bypasses the RAM
            r_fwd_hit <= push_ok && (r_tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_push_data;
    end

    // Storage; read address is the next head pointer, so the head is always ready
    pfor_ram #(
        .DATA_W (VALUE_W),
        .DEPTH  (EXC_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_tail),
        .i_wdata (i_push_data),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    assign o_head_data     = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign o_stat.empty    = empty;
    assign o_stat.overflow = r_overflow;

`ifndef SYNTH
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(EXC_DEPTH))
        else $error("exception queue level above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == '0 || r_level == LVL_W'(EXC_DEPTH)) |-> (r_head == r_tail))
        else $error("queue pointers disagree with level");
`endif

endmodule

`default_nettype wire

// File: src/pfor_exception_chain_decoder.sv
// ----------------------------------------------------------------------------
// pfor_exception_chain_decoder
// Patched frame-of-reference decoder: expands packed slot codes into values,
// patching in queued exception values along a countdown chain.
// ----------------------------------------------------------------------------
// Start and push items produce no result. A decode item is accepted, and then
// the block works through its used slots (at most eight with 4-bit slots);
// the slot sequencer emits one value per cycle unless the result output is
// stalled, since every slot depends on the countdown left by the slot before
// it. The exception queue lives in a 16-entry RAM whose head entry is
// prefetched, so consecutive exceptions pop without bubbles. Results leave
// through an output register, and the next item is accepted while the last
// result of a word still waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module pfor_exception_chain_decoder
    import pfor_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input item channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [GAP_IN_W-1:0]   i_first_gap,
    input  wire logic [VALUE_W-1:0]    i_exception_value,
    input  wire logic [WORD_BITS-1:0]  i_packed_word,
    input  wire logic [VSLOT_W-1:0]    i_valid_slots,
    // result item channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [VALUE_W-1:0]         o_value,
    output logic                       o_last,
    output logic                       o_was_exception,
    output logic                       o_queue_empty_error,
    output logic                       o_push_overflow,
    output logic [CONSUMED_W-1:0]      o_exceptions_consumed,
    output logic [LEFT_OUT_W-1:0]      o_countdown_left
);

    t_state                r_state, n_state;
    logic [SLOT_BITS-1:0]  r_cnt, n_cnt;
    logic [CONSUMED_W-1:0] r_consumed, n_consumed;
    logic [WORD_BITS-1:0]  r_word, n_word;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    logic                  in_fire, advance, push_en, pop_en;
    logic [SLOT_BITS-1:0]  code;
    logic [LEFT_W-1:0]     clip_count;
    logic [VALUE_W-1:0]    head_data;
    logic [15:0]           left_ext;
    t_fifo_stat            fifo_stat;

    assign o_ready = (r_state == ST_IDLE);
    assign in_fire = i_valid && o_ready;
    assign advance = (r_state == ST_RUN) && (!r_out_valid || i_ready);
    assign code    = r_word[SLOT_BITS-1:0];

    assign clip_count = (i_valid_slots > VSLOT_W'(SLOTS_PER_WORD)) ?
                        LEFT_W'(SLOTS_PER_WORD) : LEFT_W'(i_valid_slots);

    // Command decode, slot sequencing and result formation
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_consumed  = r_consumed;
        n_word      = r_word;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        push_en     = 1'b0;
        pop_en      = 1'b0;
        left_ext    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (t_cmd'(i_command))
                        CMD_START: begin
                            n_cnt      = SLOT_BITS'(i_first_gap);
                            n_consumed = '0;
                        end
                        CMD_PUSH: begin
                            push_en = 1'b1;
                        end
                        CMD_DECODE: begin
                            n_word = i_packed_word;
                            n_left = clip_count;
                            if (clip_count != '0) begin
                                n_state = ST_RUN;
                            end
                        end
                        default: begin
                            // unused command: ignored
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (advance) begin
                    n_out.was_exception     = 1'b0;
                    n_out.queue_empty_error = 1'b0;
                    if (r_cnt == '0) begin
                        // exception due: patch from queue, code reloads countdown
                        if (!fifo_stat.empty) begin
                            n_out.value         = head_data;
                            n_out.was_exception = 1'b1;
                            pop_en              = 1'b1;
                            if (r_consumed != CONSUMED_MAX) begin
                                n_consumed = r_consumed + 1'b1;
                            end
                        end else begin
                            n_out.value             = '0;
                            n_out.queue_empty_error = 1'b1;
                        end
                        n_cnt = code;
                    end else begin
                        n_out.value = VALUE_W'(code);
                        n_cnt       = r_cnt - 1'b1;
                    end
                    left_ext                  = 16'(n_cnt);
                    n_out.last                = (r_left == LEFT_W'(1));
                    n_out.push_overflow       = fifo_stat.overflow;
                    n_out.exceptions_consumed = n_consumed;
                    n_out.countdown_left      = left_ext[LEFT_OUT_W-1:0];
                    n_out_valid               = 1'b1;
                    n_word                    = r_word >> SLOT_BITS;
                    n_left                    = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_consumed  <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_consumed  <= n_consumed;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_out  <= n_out;
    end

    pfor_exc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_en),
        .i_push_data (i_exception_value),
        .i_pop       (pop_en),
        .o_head_data (head_data),
        .o_stat      (fifo_stat)
    );

    assign o_valid               = r_out_valid;
    assign o_value               = r_out.value;
    assign o_last                = r_out.last;
    assign o_was_exception       = r_out.was_exception;
    assign o_queue_empty_error   = r_out.queue_empty_error;
    assign o_push_overflow       = r_out.push_overflow;
    assign o_exceptions_consumed = r_out.exceptions_consumed;
    assign o_countdown_left      = r_out.countdown_left;

`ifndef SYNTH
    a_run_has_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_left != '0))
        else $error("sequencer running with no slots left");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push_en && pop_en))
        else $error("push and pop in the same cycle");

    a_last_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_left == LEFT_W'(1)) |=> (r_state == ST_IDLE && o_valid && o_last))
        else $error("final slot did not close the word");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_queue_empty_error) |-> (o_value == '0 && !o_was_exception))
        else $error("empty-queue result carries data");
`endif

endmodule

`default_nettype wire

// File: test/pfor_decode_check_pkg.sv
// ----------------------------------------------------------------------------
// pfor_decode_check_pkg
// Result prediction and checking for the patched frame-of-reference decoder.
// Tracks countdown, exception queue, consumed count and sticky overflow, and
// holds the values expected on the result channel in order.
// ----------------------------------------------------------------------------
package pfor_decode_check_pkg;

    import pfor_pkg::*;

    // Command code with no function; the block must ignore it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    class pfor_decode_scoreboard;

        logic [SLOT_BITS-1:0]  countdown;
        logic [VALUE_W-1:0]    queued_exceptions[$];
        logic [CONSUMED_W-1:0] consumed;
        logic                  overflow_seen;
        t_result               predicted_results[$];
        int                    errors;

        function new();
            countdown     = '0;
            consumed      = '0;
            overflow_seen = 1'b0;
            errors        = 0;
        endfunction

        function int exceptions_queued();
            return queued_exceptions.size();
        endfunction

        function int results_pending();
            return predicted_results.size();
        endfunction

        // One line per mismatch
        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Update the state for one accepted item and queue its results
        function void note_item(logic [CMD_W-1:0] cmd, logic [GAP_IN_W-1:0] gap,
                                logic [VALUE_W-1:0] exc, logic [WORD_BITS-1:0] word,
                                logic [VSLOT_W-1:0] slots);
            int                   n;
            logic [SLOT_BITS-1:0] code;
            t_result              r;
            case (cmd)
                CMD_START: begin
                    countdown = gap[SLOT_BITS-1:0];
                    consumed  = '0;
                end
                CMD_PUSH: begin
                    // full queue drops the value and latches overflow
                    if (queued_exceptions.size() >= EXC_DEPTH) overflow_seen = 1'b1;
                    else queued_exceptions.push_back(exc);
                end
                CMD_DECODE: begin
                    n = (slots > SLOTS_PER_WORD) ? SLOTS_PER_WORD : int'(slots);
                    for (int s = 0; s < n; s++) begin
                        code = word[s*SLOT_BITS +: SLOT_BITS];
                        r    = '0;
                        if (countdown == 0) begin
                            // exception due: patch from queue, code is next distance
                            if (queued_exceptions.size() != 0) begin
                                r.value         = queued_exceptions.pop_front();
                                r.was_exception = 1'b1;
                                if (consumed != CONSUMED_MAX) consumed++;
                            end else begin
                                r.queue_empty_error = 1'b1;
                            end
                            countdown = code;
                        end else begin
                            countdown--;
                            r.value = VALUE_W'(code);
                        end
                        r.last                = (s == n - 1);
                        r.push_overflow       = overflow_seen;
                        r.exceptions_consumed = consumed;
                        r.countdown_left      = LEFT_OUT_W'(countdown);
                        predicted_results.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result with the oldest prediction
        task check_result(t_result got);
            t_result want;
            if (predicted_results.size() == 0) begin
                report($sformatf("result with none expected, value %h", got.value));
                return;
            end
            want = predicted_results.pop_front();
            if (got.value !== want.value)
                report($sformatf("value %h, expected %h", got.value, want.value));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
            if (got.was_exception !== want.was_exception)
                report($sformatf("was_exception %b, expected %b",
                                 got.was_exception, want.was_exception));
            if (got.queue_empty_error !== want.queue_empty_error)
                report($sformatf("queue_empty_error %b, expected %b",
                                 got.queue_empty_error, want.queue_empty_error));
            if (got.push_overflow !== want.push_overflow)
                report($sformatf("push_overflow %b, expected %b",
                                 got.push_overflow, want.push_overflow));
            if (got.exceptions_consumed !== want.exceptions_consumed)
                report($sformatf("exceptions_consumed %0d, expected %0d",
                                 got.exceptions_consumed, want.exceptions_consumed));
            if (got.countdown_left !== want.countdown_left)
                report($sformatf("countdown_left %0d, expected %0d",
                                 got.countdown_left, want.countdown_left));
        endtask

    endclass

endpackage

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pfor_exception_chain_decoder.
// Directed items cover empty-queue patching, slot clipping, zero slots and
// the unused command; a long receiver stall fills the block; random
// start/push/decode sequences with bursty stalls on both channels follow,
// with a full-queue overflow in between.
// Every result is checked field by field against a predictor in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pfor_pkg::*;
    import pfor_decode_check_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RAND_A_ITEMS = 170;
    localparam int RAND_B_ITEMS = 160;
    localparam int RAND_C_ITEMS = 60;
    localparam int DRAIN_CYCLES = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [CMD_W-1:0]      i_command = CMD_START;
    logic [GAP_IN_W-1:0]   i_first_gap = '0;
    logic [VALUE_W-1:0]    i_exception_value = '0;
    logic [WORD_BITS-1:0]  i_packed_word = '0;
    logic [VSLOT_W-1:0]    i_valid_slots = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [VALUE_W-1:0]    o_value;
    logic                  o_last;
    logic                  o_was_exception;
    logic                  o_queue_empty_error;
    logic                  o_push_overflow;
    logic [CONSUMED_W-1:0] o_exceptions_consumed;
    logic [LEFT_OUT_W-1:0] o_countdown_left;

    pfor_decode_scoreboard sb = new();

    int items_sent     = 0;
    int rx_hold_req    = 0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;
    bit idling_allowed = 1'b1;

    pfor_exception_chain_decoder dut (.*);

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one item, hold it until accepted, then predict its results
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [GAP_IN_W-1:0] gap,
                             input logic [VALUE_W-1:0] exc,
                             input logic [WORD_BITS-1:0] word,
                             input logic [VSLOT_W-1:0] slots);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_command         <= cmd;
        i_first_gap       <= gap;
        i_exception_value <= exc;
        i_packed_word     <= word;
        i_valid_slots     <= slots;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(cmd, gap, exc, word, slots);
        items_sent++;
    endtask

    // Unused fields carry random junk
    task automatic start_block(input logic [GAP_IN_W-1:0] gap);
        send_item(CMD_START, gap, {$urandom, $urandom}, $urandom, VSLOT_W'($urandom));
    endtask

    task automatic push_exception(input logic [VALUE_W-1:0] exc);
        send_item(CMD_PUSH, GAP_IN_W'($urandom), exc, $urandom, VSLOT_W'($urandom));
    endtask

    task automatic decode_word(input logic [WORD_BITS-1:0] word,
                               input logic [VSLOT_W-1:0] slots);
        send_item(CMD_DECODE, GAP_IN_W'($urandom), {$urandom, $urandom}, word, slots);
    endtask

    // Sender pauses until every predicted result has been seen
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.results_pending() != 0);
    endtask

    // One random sequence: mostly start, pushes, decodes; sometimes a stray item
    task automatic random_sequence(input bit allow_overflow);
        int                   room;
        int                   n_push;
        int                   pick;
        logic [WORD_BITS-1:0] mask;
        logic [VSLOT_W-1:0]   slots;
        logic [CMD_W-1:0]     cmd;
        if (idling_allowed) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 99) < 80) begin
            start_block(($urandom_range(0, 9) < 6) ? GAP_IN_W'($urandom_range(0, 3))
                                                   : GAP_IN_W'($urandom_range(0, 15)));
            room   = EXC_DEPTH - sb.exceptions_queued();
            n_push = allow_overflow ? $urandom_range(0, room + 3) : $urandom_range(0, room);
            repeat (n_push) push_exception({$urandom, $urandom});
            repeat ($urandom_range(1, 4)) begin
                // small codes make exceptions come often
                case ($urandom_range(0, 3))
                    0:       mask = '1;
                    1:       mask = 32'h3333_3333;
                    2:       mask = 32'h1111_1111;
                    default: mask = 32'h0000_0000;
                endcase
                pick = $urandom_range(0, 9);
                if (pick < 6)       slots = VSLOT_W'(SLOTS_PER_WORD);
                else if (pick < 8)  slots = VSLOT_W'($urandom_range(1, SLOTS_PER_WORD));
                else if (pick == 8) slots = VSLOT_W'($urandom_range(SLOTS_PER_WORD + 1, 63));
                else                slots = '0;
                decode_word($urandom & mask, slots);
            end
        end else begin
            cmd = CMD_W'($urandom_range(0, 3));
            if (cmd == CMD_PUSH && !allow_overflow && sb.exceptions_queued() >= EXC_DEPTH)
                cmd = CMD_DECODE;
            send_item(cmd, GAP_IN_W'($urandom), {$urandom, $urandom}, $urandom,
                      VSLOT_W'($urandom));
        end
    endtask

    // Result side: check accepted results, drive ready with bursty stalls
    initial begin : result_sink
        int      hold;
        t_result got;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = '{value: o_value, last: o_last, was_exception: o_was_exception,
                        queue_empty_error: o_queue_empty_error,
                        push_overflow: o_push_overflow,
                        exceptions_consumed: o_exceptions_consumed,
                        countdown_left: o_countdown_left};
                sb.check_result(got);
            end
            if (rx_hold_req > 0) begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
            end else if (hold == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 19);
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Run limit
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        int base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue right after reset, zero and clipped slot counts,
        // unused command, max gap, extreme exception values
        decode_word(32'h8765_4321, 6'd8);
        decode_word(32'hFFFF_FFFF, 6'd0);
        send_item(CMD_UNUSED, 4'hF, '1, '1, '1);
        start_block(4'hF);
        push_exception(64'hFFFF_FFFF_FFFF_FFFF);
        push_exception(64'h0000_0000_0000_0000);
        push_exception(64'h8000_0000_0000_0001);
        push_exception(64'h0123_4567_89AB_CDEF);
        decode_word(32'h0000_0000, 6'd63);
        start_block(4'h0);
        decode_word(32'h0000_0000, 6'd3);
        decode_word(32'hFFFF_FFF0, 6'd9);
        decode_word(32'hA5A5_A5A5, 6'd1);
        decode_word(32'h1234_5678, 6'd32);
        repeat (3) push_exception({$urandom, $urandom});
        start_block(4'h1);
        decode_word(32'h5A5A_5A5A, 6'd7);
        send_item(CMD_UNUSED, '0, '0, '0, '0);
        decode_word(32'hFFFF_FFFF, 6'h3F);
        wait_drained();

        // Receiver stalls for a long stretch while full words keep coming
        rx_hold_req = 300;
        start_block(4'h2);
        repeat (6) push_exception({$urandom, $urandom});
        repeat (10) decode_word($urandom, VSLOT_W'(SLOTS_PER_WORD));
        wait_drained();

        // Random, queue kept from overflowing
        base = items_sent;
        while (items_sent - base < RAND_A_ITEMS) begin
            random_sequence(1'b0);
            if ($urandom_range(0, 19) == 0) wait_drained();
        end

        // Fill the queue and push past it; overflow stays set from here on
        start_block(4'h0);
        while (sb.exceptions_queued() < EXC_DEPTH) push_exception({$urandom, $urandom});
        repeat (2) push_exception({$urandom, $urandom});
        repeat (2) decode_word('0, VSLOT_W'(SLOTS_PER_WORD));

        // Random, overflow allowed
        base = items_sent;
        while (items_sent - base < RAND_B_ITEMS) begin
            random_sequence(1'b1);
            if ($urandom_range(0, 19) == 0) wait_drained();
        end

        // Last part at full rate on both sides
        idling_allowed = 1'b0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        base = items_sent;
        while (items_sent - base < RAND_C_ITEMS) random_sequence(1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.results_pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/pfor_pkg.sv
src/pfor_ram.sv
src/pfor_exc_fifo.sv
src/pfor_exception_chain_decoder.sv
test/pfor_decode_check_pkg.sv
test/testbench.sv
